[rtl/pid_step_clamped_integral_core_assert.svh]
// ----------------------------------------------------------------------------
// PID step core assertion macros
// Clocked concurrent checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef PID_STEP_CLAMPED_INTEGRAL_CORE_ASSERT_SVH
`define PID_STEP_CLAMPED_INTEGRAL_CORE_ASSERT_SVH

// same-cycle implication
`define PSCI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psci check failed");

// next-cycle implication
`define PSCI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psci check failed");

`endif

[rtl/psci_pkg.sv]
// ----------------------------------------------------------------------------
// PID step core package
// Shared widths, register indexes, serial unit requests and helpers.
// ----------------------------------------------------------------------------
package psci_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned PROD_W = 2 * DATA_W;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned TERM_W = PROD_W - 16;
	localparam int unsigned SUM_W = TERM_W + 2;
	localparam int unsigned INC_W = 58;
	localparam int unsigned ACC_W = INC_W + 1;
	localparam int unsigned D100_W = 40;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_P_GAIN    = 3'd0,
		REG_I_GAIN    = 3'd1,
		REG_D_GAIN    = 3'd2,
		REG_INIT_ERR  = 3'd3,
		REG_INIT_TIME = 3'd4,
		REG_INT_LIMIT = 3'd5
	} reg_idx_t;

	localparam logic [30:0] INT_LIMIT_RST = 31'd65536000;
	localparam logic [DATA_W-1:0] TICKS_PER_STEP = 32'd100;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] n;
		logic [DATA_W-1:0] d;
	} div_req_t;

	function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
		mag32 = v[DATA_W-1] ? (~v + 1'b1) : v;
	endfunction

	// signed product from magnitude, rounded to Q16.16 (floor of +half)
	function automatic logic signed [TERM_W-1:0] rnd_term(input logic [PROD_W-1:0] m,
		input logic neg);
		logic [PROD_W-1:0] p;
		logic [PROD_W-1:0] r;
		p = neg ? (~m + 1'b1) : m;
		r = p + PROD_W'(32768);
		rnd_term = $signed(r[PROD_W-1:16]);
	endfunction

endpackage

[rtl/psci_mul.sv]
// ----------------------------------------------------------------------------
// PID step core serial multiplier
// Unsigned 32x32 shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module psci_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  psci_pkg::mul_req_t                  req,
	output logic                                done,
	output logic [psci_pkg::PROD_W-1:0]         prod
);
	import psci_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [DATA_W-1:0] a_q;
	logic [PROD_W-1:0] p_q;
	logic [DATA_W:0]   sum;

	assign sum = {1'b0, p_q[PROD_W-1:DATA_W]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			p_q <= {{DATA_W{1'b0}}, req.b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[DATA_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = p_q;

endmodule

[rtl/psci_div.sv]
// ----------------------------------------------------------------------------
// PID step core serial divider
// Unsigned 64/32 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psci_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  psci_pkg::div_req_t                  req,
	output logic                                done,
	output logic [psci_pkg::PROD_W-1:0]         quo
);
	import psci_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [5:0]        cnt_q;
	logic [DATA_W-1:0] d_q;
	logic [DATA_W-1:0] r_q;
	logic [PROD_W-1:0] q_q;
	logic [DATA_W:0]   sh;
	logic [DATA_W+1:0] t;
	logic              ge;

	assign sh = {r_q, q_q[PROD_W-1]};
	assign t  = {1'b0, sh} - {2'b00, d_q};
	assign ge = !t[DATA_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			d_q <= req.d;
			r_q <= '0;
			q_q <= req.n;
		end else if (busy_q) begin
			r_q <= ge ? t[DATA_W-1:0] : sh[DATA_W-1:0];
			q_q <= {q_q[PROD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

[rtl/pid_step_clamped_integral_core.sv]
// ----------------------------------------------------------------------------
// PID step core with clamped integrator
// Fixed-point PID command per error sample, bit-serial multiply and divide.
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// s_*       in         s_tvalid/s_tready   tdata: error_value, timestamp
// m_*       out        m_tvalid/m_tready   tdata: drive_command; tuser: zero_interval
// cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each request makes four passes of the bit-serial multiplier and up to two passes of
// the bit-serial divider (one when the tick delta is zero), then the HOLD and UPD
// states settle and update; a new request is taken only once the core is back in
// IDLE. Reset clears control and the integral. A finished command waits in the
// output register while the next request is taken; the core stalls before its final
// update while that register is full and is not being read.
// ----------------------------------------------------------------------------
module pid_step_clamped_integral_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [63:0]                       s_tdata,   // error_value, timestamp
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [31:0]                       m_tdata,   // drive_command
	output logic                              m_tuser,   // zero_interval
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [psci_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data
);
	import psci_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_MUL_INC = 9'b000000010,
		ST_DIV_INC = 9'b000000100,
		ST_DIV_DER = 9'b000001000,
		ST_MUL_P   = 9'b000010000,
		ST_MUL_I   = 9'b000100000,
		ST_MUL_D   = 9'b001000000,
		ST_UPD     = 9'b010000000,
		ST_HOLD    = 9'b100000000
	} state_t;

	state_t state_q;

	logic [DATA_W-1:0] p_gain_q, i_gain_q, d_gain_q;
	logic [30:0]       limit_q;
	logic [DATA_W-1:0] last_err_q, last_time_q, integ_q;

	logic [DATA_W-1:0] err_q, now_q, delta_q, deriv_q;
	logic              zero_q, dneg_q;
	logic [D100_W-1:0] dmag_q;
	logic [INC_W-1:0]  inc_q;
	logic [SUM_W-1:0]  sum_q;

	logic [DATA_W-1:0] out_cmd_q;
	logic              out_zero_q, out_valid_q;

	mul_req_t          mul_req;
	div_req_t          div_req;
	logic              mul_done, div_done;
	logic [PROD_W-1:0] mul_p, div_q;

	logic              s_acc, out_free;
	logic [DATA_W-1:0] e_in, t_in, delta_in;
	logic [DATA_W:0]   diff;
	logic [D100_W-1:0] dx, d100;
	logic [DATA_W-1:0] deriv_sat;
	logic signed [TERM_W-1:0] term;
	logic              term_neg;
	logic [SUM_W-1:0]  sum_fin;
	logic [DATA_W-1:0] cmd_sat;
	logic signed [ACC_W-1:0] acc, lim, nlim;
	logic [DATA_W-1:0] integ_new;

	assign e_in     = s_tdata[31:0];
	assign t_in     = s_tdata[63:32];
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || m_tready;

	assign delta_in = t_in - last_time_q;
	assign diff     = {e_in[31], e_in} - {last_err_q[31], last_err_q};
	assign dx       = {{(D100_W-DATA_W-1){diff[DATA_W]}}, diff};
	assign d100     = (dx << 6) + (dx << 5) + (dx << 2);

	always_comb begin
		if (dneg_q) begin
			if (div_q[PROD_W-1:DATA_W] != '0 || (div_q[31] && div_q[30:0] != '0))
				deriv_sat = 32'h8000_0000;
			else
				deriv_sat = ~div_q[31:0] + 1'b1;
		end else begin
			if (div_q[PROD_W-1:31] != '0)
				deriv_sat = 32'h7FFF_FFFF;
			else
				deriv_sat = div_q[31:0];
		end
	end

	always_comb begin
		unique case (state_q)
			ST_MUL_P: term_neg = p_gain_q[31] ^ err_q[31];
			ST_MUL_I: term_neg = i_gain_q[31] ^ integ_q[31];
			default:  term_neg = d_gain_q[31] ^ deriv_q[31];
		endcase
	end

	assign term    = rnd_term(mul_p, term_neg);
	assign sum_fin = sum_q;

	always_comb begin
		if ($signed(sum_fin) > $signed(SUM_W'(32'h7FFF_FFFF)))
			cmd_sat = 32'h7FFF_FFFF;
		else if ($signed(sum_fin) < -$signed(SUM_W'(33'h0_8000_0000)))
			cmd_sat = 32'h8000_0000;
		else
			cmd_sat = sum_fin[31:0];
	end

	assign acc  = $signed({{(ACC_W-DATA_W){integ_q[31]}}, integ_q})
		+ $signed({inc_q[INC_W-1], inc_q});
	assign lim  = $signed({{(ACC_W-31){1'b0}}, limit_q});
	assign nlim = -lim;

	always_comb begin
		priority if (acc > lim)
			integ_new = lim[31:0];
		else if (acc < nlim)
			integ_new = nlim[31:0];
		else
			integ_new = acc[31:0];
	end

	always_comb begin
		mul_req = '0;
		div_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				mul_req.start = s_acc;
				mul_req.a = delta_in;
				mul_req.b = mag32(e_in);
			end
			ST_MUL_INC: begin
				div_req.start = mul_done;
				div_req.n = mul_p;
				div_req.d = TICKS_PER_STEP;
			end
			ST_DIV_INC: begin
				div_req.start = div_done && !zero_q;
				div_req.n = {{(PROD_W-D100_W){1'b0}}, dmag_q};
				div_req.d = delta_q;
				mul_req.start = div_done && zero_q;
				mul_req.a = mag32(p_gain_q);
				mul_req.b = mag32(err_q);
			end
			ST_DIV_DER: begin
				mul_req.start = div_done;
				mul_req.a = mag32(p_gain_q);
				mul_req.b = mag32(err_q);
			end
			ST_MUL_P: begin
				mul_req.start = mul_done;
				mul_req.a = mag32(i_gain_q);
				mul_req.b = mag32(integ_q);
			end
			ST_MUL_I: begin
				mul_req.start = mul_done;
				mul_req.a = mag32(d_gain_q);
				mul_req.b = mag32(deriv_q);
			end
			ST_MUL_D, ST_UPD, ST_HOLD: begin
				mul_req = '0;
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	psci_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.prod   (mul_p)
	);

	psci_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			p_gain_q    <= '0;
			i_gain_q    <= '0;
			d_gain_q    <= '0;
			limit_q     <= INT_LIMIT_RST;
			last_err_q  <= '0;
			last_time_q <= '0;
			integ_q     <= '0;
		end else begin
			if (out_valid_q && m_tready && !(state_q == ST_UPD && out_free))
				out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_P_GAIN:    p_gain_q    <= cfg_data;
					REG_I_GAIN:    i_gain_q    <= cfg_data;
					REG_D_GAIN:    d_gain_q    <= cfg_data;
					REG_INIT_ERR:  last_err_q  <= cfg_data;
					REG_INIT_TIME: last_time_q <= cfg_data;
					REG_INT_LIMIT: limit_q     <= cfg_data[30:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE:    if (s_acc) state_q <= ST_MUL_INC;
				ST_MUL_INC: if (mul_done) state_q <= ST_DIV_INC;
				ST_DIV_INC: if (div_done) state_q <= zero_q ? ST_MUL_P : ST_DIV_DER;
				ST_DIV_DER: if (div_done) state_q <= ST_MUL_P;
				ST_MUL_P:   if (mul_done) state_q <= ST_MUL_I;
				ST_MUL_I:   if (mul_done) state_q <= ST_MUL_D;
				ST_MUL_D:   if (mul_done) state_q <= ST_HOLD;
				ST_HOLD:    state_q <= ST_UPD;
				ST_UPD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						integ_q     <= integ_new;
						last_err_q  <= err_q;
						last_time_q <= now_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			err_q   <= e_in;
			now_q   <= t_in;
			delta_q <= delta_in;
			zero_q  <= (delta_in == '0);
			dneg_q  <= d100[D100_W-1];
			dmag_q  <= d100[D100_W-1] ? (~d100 + 1'b1) : d100;
			deriv_q <= '0;
		end
		if (state_q == ST_DIV_INC && div_done)
			inc_q <= err_q[31] ? (~div_q[INC_W-1:0] + 1'b1) : div_q[INC_W-1:0];
		if (state_q == ST_DIV_DER && div_done)
			deriv_q <= deriv_sat;
		if (state_q == ST_MUL_P && mul_done)
			sum_q <= SUM_W'(term);
		if ((state_q == ST_MUL_I || state_q == ST_MUL_D) && mul_done)
			sum_q <= sum_q + {{(SUM_W-TERM_W){term[TERM_W-1]}}, term};
		if (state_q == ST_UPD && out_free) begin
			out_cmd_q  <= cmd_sat;
			out_zero_q <= zero_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_cmd_q;
	assign m_tuser  = out_zero_q;

endmodule

[rtl/psci_chk.sv]
// ----------------------------------------------------------------------------
// PID step core port checker
// Watches the stream ports of the core over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "pid_step_clamped_integral_core_assert.svh"

module psci_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);
	logic s_acc;
	logic m_wait;

	assign s_acc  = s_tvalid && s_tready;
	assign m_wait = m_tvalid && !m_tready;

	`PSCI_ASSERT_NEXT(a_busy_after_req, s_acc, !s_tready)
	`PSCI_ASSERT_NEXT(a_no_instant_result, s_acc, !$rose(m_tvalid))
	`PSCI_ASSERT_NEXT(a_out_valid_holds, m_wait, m_tvalid)
	`PSCI_ASSERT_NEXT(a_out_data_holds, m_wait, $stable(m_tdata) && $stable(m_tuser))

endmodule

bind pid_step_clamped_integral_core psci_chk u_psci_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[tb/sv/tb_pid_step_clamped_integral_core.sv]
// ----------------------------------------------------------------------------
// PID step core testbench
// Streams error samples and timestamps through the core across several gain
// and limit settings and checks each command and zero-interval flag against a
// fixed-point model of the controller kept in the bench.
// ----------------------------------------------------------------------------
module tb_pid_step_clamped_integral_core;
	import psci_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int SETTLE_CYCLES = 300;
	localparam int HOLD_CYCLES = 3000;

	typedef struct {
		logic [31:0] cmd;
		logic        zero;
	} command_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [63:0]          s_tdata = '0;      // error_value, timestamp
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [31:0]          m_tdata;           // drive_command
	logic                 m_tuser;           // zero_interval
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	longint   kp, ki, kd, init_err, int_limit, prev_err, integ;
	logic [31:0] init_tick, prev_tick;
	command_t pending_cmds[$];
	int       fail_count = 0;
	bit       steady = 1'b0;
	bit       hold_go = 1'b0;
	bit       hold_on = 1'b0;

	pid_step_clamped_integral_core i_dut (.*);

	always #4 clk = ~clk;

	initial begin
		#(8 * 3000000);
		$display("tb_pid_step_clamped_integral_core failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		fail_count++;
	endtask

	function automatic longint clamp32(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint round_q16(input longint a, input longint b);
		longint p;
		p = a * b + 32768;
		return p >>> 16;
	endfunction

	function automatic int pick_gap();
		if (steady || $urandom_range(99) >= 25) return 0;
		return $urandom_range(1, 6);
	endfunction

	task automatic compute_command(input logic [31:0] e, input logic [31:0] now);
		longint ev, delta, deriv, acc;
		logic [31:0] d32;
		command_t r;
		ev = longint'($signed(e));
		d32 = now - prev_tick;
		delta = longint'({32'd0, d32});
		deriv = 0;
		if (delta != 0) deriv = clamp32(((ev - prev_err) * 100) / delta);
		r.cmd = 32'(clamp32(round_q16(kp, ev) + round_q16(ki, integ) + round_q16(kd, deriv)));
		r.zero = (delta == 0);
		acc = integ + (delta * ev) / 100;
		if (acc > int_limit) acc = int_limit;
		else if (acc < -int_limit) acc = -int_limit;
		integ = acc;
		prev_err = ev;
		prev_tick = now;
		pending_cmds.push_back(r);
	endtask

	task automatic send_sample(input logic [31:0] e, input logic [31:0] ts);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {ts, e};
		do @(posedge clk); while (!s_tready);
		compute_command(e, ts);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_P_GAIN: kp = longint'($signed(val));
			REG_I_GAIN: ki = longint'($signed(val));
			REG_D_GAIN: kd = longint'($signed(val));
			REG_INIT_ERR: begin
				init_err = longint'($signed(val));
				prev_err = init_err;
			end
			REG_INIT_TIME: begin
				init_tick = val;
				prev_tick = val;
			end
			REG_INT_LIMIT: int_limit = longint'({33'd0, val[30:0]});
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [31:0] p, input logic [31:0] i,
		input logic [31:0] d, input logic [31:0] lim);
		write_reg(REG_P_GAIN, p);
		write_reg(REG_I_GAIN, i);
		write_reg(REG_D_GAIN, d);
		write_reg(REG_INT_LIMIT, lim);
		write_reg(REG_INIT_ERR, $urandom);
		write_reg(REG_INIT_TIME, $urandom);
	endtask

	function automatic logic [31:0] rand_gain();
		return 32'($signed($urandom) >>> $urandom_range(4, 31));
	endfunction

	task automatic rand_sample();
		logic [31:0] e, ts;
		int r;
		r = $urandom_range(99);
		if (r < 8) ts = prev_tick;
		else if (r < 16) ts = $urandom;
		else if (r < 20) ts = prev_tick + $urandom_range(32'h10000, 32'hFFFFFFFF);
		else ts = prev_tick + $urandom_range(1, 2000);
		r = $urandom_range(99);
		if (r < 10) e = $urandom;
		else if (r < 15) e = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
		else e = $urandom_range(0, 32'h3FFFFF) - 32'h200000;
		send_sample(e, ts);
	endtask

	// checker and receiver
	always @(posedge clk) begin
		command_t x;
		if (m_tvalid && m_tready) begin
			if (pending_cmds.size() == 0) begin
				report_mismatch($sformatf("unexpected command %h", m_tdata));
			end else begin
				x = pending_cmds.pop_front();
				if (m_tdata !== x.cmd)
					report_mismatch($sformatf("drive_command %h, want %h", m_tdata, x.cmd));
				if (m_tuser !== x.zero)
					report_mismatch($sformatf("zero_interval %b, want %b", m_tuser, x.zero));
			end
		end
		if (hold_on) m_tready <= 1'b0;
		else if (steady) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(99) >= 25);
	end

	// receiver hold-off
	always @(posedge clk) begin
		if (hold_go) begin
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	task automatic test_directed();
		load_settings(32'h00010000, 32'h00008000, 32'h00004000, 32'd65536000);
		write_reg(REG_INIT_TIME, 32'hFFFFFFF0);
		send_sample(32'h00010000, 32'hFFFFFFF0);
		send_sample(32'h00020000, 32'h00000010);
		send_sample(32'h7FFFFFFF, 32'h00000011);
		send_sample(32'h80000000, 32'h00000012);
		send_sample(32'h7FFFFFFF, 32'h7FFFFFFF);
		send_sample(32'h7FFFFFFF, 32'h7FFFFFFE);
		send_sample(32'h80000000, 32'h7FFFFFFD);
		send_sample(32'h00000000, 32'h7FFFFFFD);
		send_sample(32'hFFFFFFFF, 32'h7FFFFFFE);
		wait_drained();
		load_settings(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_sample(32'h7FFFFFFF, prev_tick + 32'd1000000);
		send_sample(32'h7FFFFFFF, prev_tick + 32'd1000000);
		send_sample(32'h80000000, prev_tick + 32'd1);
		send_sample(32'h80000000, prev_tick);
		wait_drained();
		load_settings(32'h80000000, 32'h80000000, 32'h80000000, 32'h00000000);
		send_sample(32'h80000000, prev_tick + 32'd50);
		send_sample(32'h7FFFFFFF, prev_tick + 32'd99);
		send_sample(32'h12345678, prev_tick + 32'd100);
		wait_drained();
		write_reg(REG_SPARE_LO, 32'hFFFFFFFF);
		write_reg(REG_SPARE_HI, 32'hA5A5A5A5);
		write_reg(REG_INT_LIMIT, 32'hFFFFFFFF);
		send_sample(32'h40000000, prev_tick + 32'd300);
		send_sample(32'hC0000000, prev_tick + 32'd300);
		wait_drained();
	endtask

	task automatic test_random(input int phases, input int per_phase);
		for (int ph = 0; ph < phases; ph++) begin
			load_settings(rand_gain(), rand_gain(), rand_gain(),
				($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(0, 32'h0FFFFFFF)));
			steady = (ph == 1);
			for (int n = 0; n < per_phase; n++) rand_sample();
			steady = 1'b0;
			wait_drained();
		end
	endtask

	task automatic test_backpressure();
		load_settings(rand_gain(), rand_gain(), rand_gain(), 32'd65536000);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		for (int n = 0; n < 30; n++) rand_sample();
		wait_drained();
	endtask

	initial begin
		kp = 0;
		ki = 0;
		kd = 0;
		init_err = 0;
		init_tick = '0;
		int_limit = 65536000;
		prev_err = 0;
		prev_tick = '0;
		integ = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(6, 233);
		if (fail_count == 0) begin
			$display("tb_pid_step_clamped_integral_core passed");
		end else begin
			$display("tb_pid_step_clamped_integral_core failed");
		end
		$finish;
	end

endmodule
